@@ design/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/mcs_pkg.sv @@
package mcs_pkg;

  // One input request: a field element with its row data.
  typedef struct packed {
    logic signed [31:0] correction_value;
    logic signed [31:0] source_value;
    logic signed [31:0] product_value;
    logic signed [31:0] diagonal_value;
    logic               last_element;
  } item_t;

  // One result request.
  typedef struct packed {
    logic signed [31:0] updated_value;
    logic [17:0]        scale_factor;
    logic               factor_valid;
    logic               zero_diagonal;
    logic               saturated;
  } result_t;

  // Item as classified by the front part.
  typedef struct packed {
    item_t item;
    logic  zero_diag;
  } job_t;

  // Back part sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC_NUM,
    ST_ACC_DEN,
    ST_DIV,
    ST_FIX,
    ST_FAC,
    ST_DONE
  } back_state_t;

  localparam logic signed [63:0] ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] ACC_MIN = -64'sh7FFF_FFFF_FFFF_FFFF;

  // Saturating accumulate; bit 64 of the result flags a clip.
  function automatic logic [64:0] sat_add(input logic signed [63:0] acc,
                                          input logic signed [63:0] x);
    logic signed [64:0] sum;
    sum = {acc[63], acc} + {x[63], x};
    if (sum > $signed({ACC_MAX[63], ACC_MAX})) begin
      return {1'b1, ACC_MAX};
    end else if (sum < $signed({ACC_MIN[63], ACC_MIN})) begin
      return {1'b1, ACC_MIN};
    end
    return {1'b0, sum[63:0]};
  endfunction

endpackage

@@ design/mcs_front.sv @@
module mcs_front
  import mcs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  output logic  full,
  input  item_t item,
  output logic  job_valid,
  output job_t  job,
  input  logic  job_take
);

  job_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;

  assign full      = (count == 2'd2);
  assign do_push   = push && !full;
  assign job_valid = (count != 2'd0);
  assign job       = slot[rd_ptr];

  // Classify and store incoming requests.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr].item      <= item;
      slot[wr_ptr].zero_diag <= (item.diagonal_value == 32'sd0);
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (job_take) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, job_take};
    end
  end

endmodule

@@ design/mcs_back.sv @@
module mcs_back
  import mcs_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  input  job_t    job,
  output logic    job_take,
  output logic    res_valid,
  output result_t res,
  input  logic    pop
);

  localparam int DW  = 33 + FRACTION_BITS;
  localparam int CW  = $clog2(DW + 1);
  localparam int FCW = $clog2(FRACTION_BITS + 1);

  back_state_t state, state_next;

  job_t                     cur;
  logic signed [63:0]       prod;
  logic signed [63:0]       num_sum;
  logic signed [63:0]       den_sum;
  logic                     sat;
  logic [32:0]              div_rem;
  logic [DW-1:0]            div_quo;
  logic [31:0]              div_den;
  logic                     div_neg;
  logic [CW-1:0]            div_cnt;
  logic signed [31:0]       upd;
  logic [63:0]              fac_rem;
  logic [62:0]              fac_den;
  logic [FRACTION_BITS-1:0] fac_frac;
  logic [1:0]               fac_int;
  logic [FCW-1:0]           fac_cnt;
  logic                     load_res;

  // Combinational helpers.
  logic [64:0]        acc_res;
  logic signed [63:0] scaled;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [DW:0]   quo_s;
  logic signed [DW+1:0] upd_sum;
  logic               upd_ok;
  logic [62:0]        n_mag;
  logic [62:0]        d_mag;
  logic               same_sign;
  logic [63:0]        fac_sh;
  logic [FRACTION_BITS+1:0] fac_full;

  assign scaled   = prod >>> FRACTION_BITS;
  assign acc_res  = sat_add((state == ST_ACC_NUM) ? num_sum : den_sum, scaled);
  assign diff     = {cur.item.source_value[31], cur.item.source_value}
                  - {cur.item.product_value[31], cur.item.product_value};
  assign diff_mag = diff[32] ? 33'(-diff) : 33'(diff);
  assign rem_sh   = {div_rem[31:0], div_quo[DW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, div_den});
  assign quo_s    = div_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign upd_sum  = (DW+2)'(cur.item.correction_value) + (DW+2)'(quo_s);
  assign upd_ok   = (upd_sum[DW+1:31] == '0) || (upd_sum[DW+1:31] == '1);
  assign n_mag    = num_sum[63] ? 63'(-num_sum) : num_sum[62:0];
  assign d_mag    = den_sum[63] ? 63'(-den_sum) : den_sum[62:0];
  assign same_sign = (num_sum > 0 && den_sum > 0) || (num_sum < 0 && den_sum < 0);
  assign fac_sh   = {fac_rem[62:0], 1'b0};
  assign fac_full = {fac_int, fac_frac};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (job_valid) state_next = ST_MUL;
      ST_MUL:     state_next = ST_ACC_NUM;
      ST_ACC_NUM: state_next = ST_ACC_DEN;
      ST_ACC_DEN: state_next = cur.zero_diag ? ST_FIX : ST_DIV;
      ST_DIV:     if (div_cnt == CW'(1)) state_next = ST_FIX;
      ST_FIX:     state_next = cur.item.last_element ? ST_FAC : ST_DONE;
      ST_FAC:     if (fac_cnt == FCW'(0)) state_next = ST_DONE;
      ST_DONE:    if (!res_valid || pop) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs of the sequencer.
  always_comb begin
    job_take = (state == ST_IDLE) && job_valid;
    load_res = (state == ST_DONE) && (!res_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // Accumulators: reset to zero, cleared after the last element.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_sum <= '0;
      den_sum <= '0;
    end else if (state == ST_ACC_NUM) begin
      num_sum <= acc_res[63:0];
    end else if (state == ST_ACC_DEN) begin
      den_sum <= acc_res[63:0];
    end else if (load_res && cur.item.last_element) begin
      num_sum <= '0;
      den_sum <= '0;
    end
  end

  // Datapath: products, update divider, factor divider.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        cur <= job;
        sat <= 1'b0;
      end
      ST_MUL: begin
        prod <= 64'(cur.item.source_value) * 64'(cur.item.correction_value);
      end
      ST_ACC_NUM: begin
        sat  <= sat | acc_res[64];
        prod <= 64'(cur.item.product_value) * 64'(cur.item.correction_value);
      end
      ST_ACC_DEN: begin
        sat     <= sat | acc_res[64];
        div_rem <= '0;
        div_quo <= {diff_mag, {FRACTION_BITS{1'b0}}};
        div_den <= cur.item.diagonal_value[31] ? 32'(-cur.item.diagonal_value)
                                               : 32'(cur.item.diagonal_value);
        div_neg <= diff[32] ^ cur.item.diagonal_value[31];
        div_cnt <= CW'(DW);
      end
      ST_DIV: begin
        div_rem <= rem_ge ? 33'(rem_sh - {1'b0, div_den}) : rem_sh;
        div_quo <= {div_quo[DW-2:0], rem_ge};
        div_cnt <= div_cnt - CW'(1);
      end
      ST_FIX: begin
        // Update with saturation, then set up the factor.
        if (cur.zero_diag) begin
          upd <= cur.item.correction_value;
        end else if (upd_ok) begin
          upd <= upd_sum[31:0];
        end else begin
          upd <= upd_sum[DW+1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          sat <= 1'b1;
        end
        fac_den  <= d_mag;
        fac_frac <= '0;
        if (!same_sign || n_mag < d_mag) begin
          fac_int <= 2'd1;
          fac_cnt <= '0;
        end else if ({1'b0, n_mag} > {d_mag, 1'b0}) begin
          fac_int <= 2'd2;
          fac_cnt <= '0;
        end else if ({1'b0, n_mag} == {d_mag, 1'b0}) begin
          fac_int <= 2'd2;
          fac_rem <= '0;
          fac_cnt <= FCW'(FRACTION_BITS);
        end else begin
          fac_int <= 2'd1;
          fac_rem <= {1'b0, n_mag - d_mag};
          fac_cnt <= FCW'(FRACTION_BITS);
        end
      end
      ST_FAC: begin
        if (fac_cnt != FCW'(0)) begin
          if (fac_sh >= {1'b0, fac_den}) begin
            fac_rem  <= fac_sh - {1'b0, fac_den};
            fac_frac <= {fac_frac[FRACTION_BITS-2:0], 1'b1};
          end else begin
            fac_rem  <= fac_sh;
            fac_frac <= {fac_frac[FRACTION_BITS-2:0], 1'b0};
          end
          fac_cnt <= fac_cnt - FCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (load_res) begin
      res.updated_value <= upd;
      res.scale_factor  <= cur.item.last_element ? 18'(fac_full) : 18'd0;
      res.factor_valid  <= cur.item.last_element;
      res.zero_diagonal <= cur.zero_diag;
      res.saturated     <= sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)           res_valid <= 1'b0;
    else if (load_res) res_valid <= 1'b1;
    else if (pop)      res_valid <= 1'b0;
  end

endmodule

@@ design/multigrid_correction_scaling_core.sv @@
// Channel | Direction | Handshake       | Payload
// item    | in        | push / full     | item_t
// result  | out       | pop / empty     | result_t
//
// In the back part of each request, the bit-serial update divider runs 33 + FRACTION_BITS
// steps (FRACTION_BITS = 16 for Q16.16), and a zero diagonal skips it. The last element
// also runs the factor divider.
// A waiting result holds the back part until it is popped.
// A two-entry queue keeps taking requests while the back part works or a result waits.
// Reset is synchronous; it empties both queues and clears the dot-product sums.
module multigrid_correction_scaling_core
  import mcs_pkg::*;
#(
  parameter int FRACTION_BITS = 16
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  output logic    full,
  input  item_t   item,
  output logic    empty,
  input  logic    pop,
  output result_t result
);

  logic job_valid;
  logic job_take;
  job_t job;
  logic res_valid;

  mcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  mcs_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .res_valid (res_valid),
    .res       (result),
    .pop       (pop)
  );

  assign empty = !res_valid;

endmodule

@@ design/mcs_checker.sv @@
`include "assert_macros.svh"

module mcs_checker
  import mcs_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    full,
  input logic    empty,
  input logic    pop,
  input result_t result
);

  // Reset leaves no result and room for requests.
  `ASSERT_ANY(a_reset_clear, rst |=> (empty && !full), "queues not empty after reset")

  // A waiting result is only removed by a pop.
  `ASSERT_CLK(a_result_held, (!empty && !pop) |=> !empty, "result vanished without pop")

  // A waiting result does not change until taken.
  `ASSERT_CLK(a_result_stable, (!empty && !pop) |=> $stable(result), "result changed while waiting")

  // Only the last element carries a factor.
  `ASSERT_CLK(a_factor_zero, (!empty && !result.factor_valid) |-> (result.scale_factor == 18'd0),
              "factor on non-last result")

endmodule

bind multigrid_correction_scaling_core mcs_checker u_mcs_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .result (result)
);
